>>> hw/rtl/segment_line_predicate_unit_assert.svh
// ----------------------------------------------------------------------------
// segment_line_predicate_unit assertion macros
// Shorthand for clocked assertions; expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_LINE_PREDICATE_UNIT_ASSERT_SVH
`define SEGMENT_LINE_PREDICATE_UNIT_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define SLP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define SLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp_pkg
// Function codes and answer codes of the segment and line predicate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package slp_pkg;

    typedef enum logic [1:0] {
        FUNC_SIDE      = 2'd0,
        FUNC_ON_SEG    = 2'd1,
        FUNC_LINE_REL  = 2'd2,
        FUNC_SEG_ISECT = 2'd3
    } func_t;

    localparam int ANSWER_BITS = 3;
    localparam int OUT_TDATA_W = 8;

    localparam logic [ANSWER_BITS-1:0] ANS_MINUS_ONE = 3'b111;
    localparam logic [ANSWER_BITS-1:0] ANS_ZERO      = 3'd0;
    localparam logic [ANSWER_BITS-1:0] ANS_ONE       = 3'd1;
    localparam logic [ANSWER_BITS-1:0] ANS_TWO       = 3'd2;

    // term slots in the product array
    localparam int T_CR_ABC = 0;
    localparam int T_CR_ABD = 1;
    localparam int T_CR_CDA = 2;
    localparam int T_CR_CDB = 3;
    localparam int T_PAR    = 4;
    localparam int T_BD_C   = 5;
    localparam int T_BD_D   = 6;
    localparam int T_BD_A   = 7;
    localparam int T_BD_B   = 8;
    localparam int NUM_TERMS = 9;

endpackage

`default_nettype wire

>>> hw/rtl/slp_cross.sv
// ----------------------------------------------------------------------------
// slp_cross
// Two-stage p*q - r*s: products registered, then their difference registered.
// ----------------------------------------------------------------------------
`default_nettype none

module slp_cross #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [COORD_BITS:0]        p,
    input  wire logic signed [COORD_BITS:0]        q,
    input  wire logic signed [COORD_BITS:0]        r,
    input  wire logic signed [COORD_BITS:0]        s,
    output logic signed      [2*COORD_BITS+2:0]    result
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int RW = PW + 1;

    logic signed [PW-1:0] pq_reg;
    logic signed [PW-1:0] rs_reg;
    logic signed [RW-1:0] result_reg;
    logic signed [PW-1:0] pq_next;
    logic signed [PW-1:0] rs_next;
    logic signed [RW-1:0] result_next;

    always_comb
    begin
        pq_next     = PW'(p) * PW'(q);
        rs_next     = PW'(r) * PW'(s);
        result_next = RW'(pq_reg) - RW'(rs_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pq_reg     <= pq_next;
            rs_reg     <= rs_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

>>> hw/rtl/segment_line_predicate_unit.sv
// Pipeline: the difference stage loads at the edge that accepts a request, then the product,
// sum and decision/output stages follow in that order, and the answer shows on m_tvalid.
// Throughput: one request per cycle; the whole pipeline stalls only while an answer
// waits on m_tready. Reset clears the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// segment_line_predicate_unit
// Exact side, on-segment, line-relation and segment-intersection predicates.
// ----------------------------------------------------------------------------
`default_nettype none

`include "segment_line_predicate_unit_assert.svh"

module segment_line_predicate_unit
    import slp_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic s_tvalid,
    output logic      s_tready,
    // func[1:0], a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y (each COORD_BITS), zero pad
    input  wire logic [((2+8*COORD_BITS+7)/8)*8-1:0] s_tdata,

    output logic      m_tvalid,
    input  wire logic m_tready,
    // answer[2:0], zero pad
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int RW = 2 * DW + 1;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [RW-1:0] term_t;

    function automatic diff_t dif(input coord_t x, input coord_t y);
        return DW'(x) - DW'(y);
    endfunction

    // ---------------- input unpack ----------------
    func_t  in_func;
    coord_t ax, ay, bx, by, cx, cy, dx, dy;

    always_comb
    begin
        in_func = func_t'(s_tdata[1:0]);
        ax = s_tdata[2+0*CB +: CB];
        ay = s_tdata[2+1*CB +: CB];
        bx = s_tdata[2+2*CB +: CB];
        by = s_tdata[2+3*CB +: CB];
        cx = s_tdata[2+4*CB +: CB];
        cy = s_tdata[2+5*CB +: CB];
        dx = s_tdata[2+6*CB +: CB];
        dy = s_tdata[2+7*CB +: CB];
    end

    // ---------------- pipeline control ----------------
    logic en;
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= s_tvalid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: coordinate differences ----------------
    // every term is written as p*q - r*s; dot products flip one factor
    diff_t p_next [NUM_TERMS];
    diff_t q_next [NUM_TERMS];
    diff_t r_next [NUM_TERMS];
    diff_t s_next [NUM_TERMS];
    diff_t p_reg  [NUM_TERMS];
    diff_t q_reg  [NUM_TERMS];
    diff_t r_reg  [NUM_TERMS];
    diff_t s_reg  [NUM_TERMS];
    func_t func1_reg, func2_reg, func3_reg;

    always_comb
    begin
        p_next[T_CR_ABC] = dif(bx, ax); q_next[T_CR_ABC] = dif(cy, ay);
        r_next[T_CR_ABC] = dif(by, ay); s_next[T_CR_ABC] = dif(cx, ax);

        p_next[T_CR_ABD] = dif(bx, ax); q_next[T_CR_ABD] = dif(dy, ay);
        r_next[T_CR_ABD] = dif(by, ay); s_next[T_CR_ABD] = dif(dx, ax);

        p_next[T_CR_CDA] = dif(dx, cx); q_next[T_CR_CDA] = dif(ay, cy);
        r_next[T_CR_CDA] = dif(dy, cy); s_next[T_CR_CDA] = dif(ax, cx);

        p_next[T_CR_CDB] = dif(dx, cx); q_next[T_CR_CDB] = dif(by, cy);
        r_next[T_CR_CDB] = dif(dy, cy); s_next[T_CR_CDB] = dif(bx, cx);

        p_next[T_PAR]    = dif(bx, ax); q_next[T_PAR]    = dif(dy, cy);
        r_next[T_PAR]    = dif(by, ay); s_next[T_PAR]    = dif(dx, cx);

        p_next[T_BD_C]   = dif(cx, ax); q_next[T_BD_C]   = dif(cx, bx);
        r_next[T_BD_C]   = dif(cy, ay); s_next[T_BD_C]   = dif(by, cy);

        p_next[T_BD_D]   = dif(dx, ax); q_next[T_BD_D]   = dif(dx, bx);
        r_next[T_BD_D]   = dif(dy, ay); s_next[T_BD_D]   = dif(by, dy);

        p_next[T_BD_A]   = dif(ax, cx); q_next[T_BD_A]   = dif(ax, dx);
        r_next[T_BD_A]   = dif(ay, cy); s_next[T_BD_A]   = dif(dy, ay);

        p_next[T_BD_B]   = dif(bx, cx); q_next[T_BD_B]   = dif(bx, dx);
        r_next[T_BD_B]   = dif(by, cy); s_next[T_BD_B]   = dif(dy, by);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= p_next;
            q_reg     <= q_next;
            r_reg     <= r_next;
            s_reg     <= s_next;
            func1_reg <= in_func;
            func2_reg <= func1_reg;
            func3_reg <= func2_reg;
        end
    end

    // ---------------- stages 2 and 3: products and differences ----------------
    term_t term [NUM_TERMS];

    for (genvar k = 0; k < NUM_TERMS; k++)
    begin : g_term
        slp_cross #(
            .COORD_BITS (COORD_BITS)
        ) u_cross (
            .clk    (clk),
            .en     (en),
            .p      (p_reg[k]),
            .q      (q_reg[k]),
            .r      (r_reg[k]),
            .s      (s_reg[k]),
            .result (term[k])
        );
    end

    // ---------------- stage 4: decision ----------------
    logic [NUM_TERMS-1:0] zero, neg, nonpos;

    always_comb
    begin
        for (int k = 0; k < NUM_TERMS; k++)
        begin
            zero[k]   = (term[k] == '0);
            neg[k]    = term[k][RW-1];
            nonpos[k] = zero[k] || neg[k];
        end
    end

    logic                   proper;
    logic                   touch;
    logic [ANSWER_BITS-1:0] answer_next;
    logic [ANSWER_BITS-1:0] answer_reg;

    always_comb
    begin
        // opposite nonzero signs on both pairs
        proper = !zero[T_CR_ABC] && !zero[T_CR_ABD] && (neg[T_CR_ABC] != neg[T_CR_ABD]) &&
                 !zero[T_CR_CDA] && !zero[T_CR_CDB] && (neg[T_CR_CDA] != neg[T_CR_CDB]);
        touch  = (zero[T_CR_ABC] && nonpos[T_BD_C]) ||
                 (zero[T_CR_ABD] && nonpos[T_BD_D]) ||
                 (zero[T_CR_CDA] && nonpos[T_BD_A]) ||
                 (zero[T_CR_CDB] && nonpos[T_BD_B]);

        unique case (func3_reg)
            FUNC_SIDE:
                answer_next = zero[T_CR_ABC] ? ANS_ZERO :
                              (neg[T_CR_ABC] ? ANS_MINUS_ONE : ANS_ONE);
            FUNC_ON_SEG:
                answer_next = (zero[T_CR_ABC] && nonpos[T_BD_C]) ? ANS_ONE : ANS_ZERO;
            FUNC_LINE_REL:
                answer_next = !zero[T_PAR] ? ANS_TWO :
                              (zero[T_CR_CDA] ? ANS_ONE : ANS_ZERO);
            FUNC_SEG_ISECT:
                answer_next = proper ? ANS_TWO : (touch ? ANS_ONE : ANS_ZERO);
            default:
                answer_next = ANS_ZERO;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            answer_reg <= answer_next;
        end
    end

    assign m_tdata = {{(OUT_TDATA_W-ANSWER_BITS){1'b0}}, answer_reg};

    // ---------------- assertions ----------------
    `SLP_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, v1_reg,
        "accepted request did not enter the first stage")
    `SLP_ASSERT_NEXT(a_stall_holds, !en, $stable({v1_reg, v2_reg, v3_reg}),
        "stage valid bits moved during a stall")
    `SLP_ASSERT_NEXT(a_drain_out, v3_reg && en, m_tvalid,
        "last stage did not reach the output register")
    `SLP_ASSERT_NOW(a_answer_code, m_tvalid,
        answer_reg == ANS_MINUS_ONE || answer_reg == ANS_ZERO ||
        answer_reg == ANS_ONE || answer_reg == ANS_TWO,
        "answer carries an undefined code")

endmodule

`default_nettype wire
